// ===== rtl/erx_pkg.sv =====
// ----------------------------------------------------------------------------
// erx_pkg: shared types and constants of the receive address filter
// Holds the register indexes, drop reason codes, length limits, the queue
// entry and configuration types, and the CRC helper functions.
// ----------------------------------------------------------------------------
package erx_pkg;

   // Field widths fixed by the frame format
   localparam int unsigned MAC_WIDTH    = 48;
   localparam int unsigned ETYPE_WIDTH  = 16;
   localparam int unsigned HASH_WIDTH   = 6;
   localparam int unsigned TABLE_WIDTH  = 64;
   localparam int unsigned REASON_WIDTH = 3;
   localparam int unsigned COUNT_WIDTH  = 32;
   localparam int unsigned OVER_WIDTH   = 16;
   localparam int unsigned CSR_IDX_WIDTH  = 3;
   localparam int unsigned CSR_DATA_WIDTH = 64;
   localparam int unsigned LIMIT_WIDTH  = 14;

   // Configuration register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_STATION_MAC    = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HASH_TABLE     = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ACCEPT_ALL     = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ACCEPT_BCAST   = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ACCEPT_ALL_MC  = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HASH_ENABLE    = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_JUMBO_ENABLE   = 3'd6;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GIGABIT_MODE   = 3'd7;

   // Drop reason codes
   localparam logic [REASON_WIDTH-1:0] REASON_NONE      = 3'd0;
   localparam logic [REASON_WIDTH-1:0] REASON_TOO_LONG  = 3'd1;
   localparam logic [REASON_WIDTH-1:0] REASON_BCAST_OFF = 3'd2;
   localparam logic [REASON_WIDTH-1:0] REASON_MCAST_OFF = 3'd3;
   localparam logic [REASON_WIDTH-1:0] REASON_HASH_MISS = 3'd4;
   localparam logic [REASON_WIDTH-1:0] REASON_UCAST_MIS = 3'd5;

   // Frame constants
   localparam logic [31:0]            CRC_POLY   = 32'h04c1_1db7;
   localparam logic [31:0]            CRC_INIT   = 32'hffff_ffff;
   localparam logic [ETYPE_WIDTH-1:0] VLAN_TYPE  = 16'h8100;
   localparam logic [MAC_WIDTH-1:0]   BCAST_MAC  = 48'hffff_ffff_ffff;
   localparam logic [23:0]            MCAST_OUI  = 24'h01_005e;
   localparam logic [7:0]             MCAST_MAX4 = 8'h7f;

   // Length limits in bytes, without CRC
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_STD       = 14'd1514;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_STD_VLAN  = 14'd1518;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_JUMBO     = 14'd9212;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_JUMBO_VLAN = 14'd9216;

   // Depth of the queue between classification and counting
   localparam int unsigned QUEUE_DEPTH = 2;

   // Configuration as seen by the classifier
   typedef struct packed {
      logic [MAC_WIDTH-1:0]   station_mac;
      logic [TABLE_WIDTH-1:0] hash_table;
      logic                   accept_all;
      logic                   accept_broadcast;
      logic                   accept_all_multicast;
      logic                   hash_enable;
      logic                   jumbo_enable;
      logic                   gigabit_mode;
   } cfg_type;

   // One classified request waiting for the back end
   typedef struct packed {
      logic                    accept;
      logic [REASON_WIDTH-1:0] drop_reason;
      logic                    is_broadcast;
      logic                    is_multicast;
      logic [HASH_WIDTH-1:0]   hash_index;
      logic                    too_long;
   } entry_type;

   // One byte of the CRC, least significant bit first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc_i,
                                            input logic [7:0]  data_i);
      logic [31:0] crc_v;
      logic        fb;
      crc_v = crc_i;
      for (int b = 0; b < 8; b++) begin
         fb    = crc_v[31] ^ data_i[b];
         crc_v = {crc_v[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
      end
      return crc_v;
   endfunction

   // Hash index: inverted CRC, top byte bit reversed, upper six bits kept
   function automatic logic [HASH_WIDTH-1:0] hash_of(input logic [31:0] crc_i);
      logic [31:0]           inv;
      logic [HASH_WIDTH-1:0] idx;
      inv = ~crc_i;
      for (int i = 0; i < HASH_WIDTH; i++) begin
         idx[i] = inv[24 + HASH_WIDTH - 1 - i];
      end
      return idx;
   endfunction

endpackage

// ===== rtl/ethernet_rx_address_filter.sv =====
// Path: an accepted request is written into the queue, then into the result register.
// Throughput: one request per cycle while not stalled; the classifier and the
// counters each take one per cycle, with a two-entry queue between them.
// Reset: synchronous, active high; clears counters, configuration and the queue.
// ----------------------------------------------------------------------------
// ethernet_rx_address_filter: receive address filter with multicast hash
// Classifies each frame header by length and destination address, keeps the
// frame statistics and reports accept or drop with the reason.
// ----------------------------------------------------------------------------
module ethernet_rx_address_filter #(
   parameter int unsigned LENGTH_WIDTH = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Configuration write port
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [erx_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [erx_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   // Request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [erx_pkg::MAC_WIDTH-1:0]        req_dest_mac,
   input  logic [erx_pkg::ETYPE_WIDTH-1:0]      req_ether_type,
   input  logic [LENGTH_WIDTH-1:0]              req_frame_length,
   // Result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_accept,
   output logic [erx_pkg::REASON_WIDTH-1:0]     rsp_drop_reason,
   output logic                                 rsp_is_broadcast,
   output logic                                 rsp_is_multicast,
   output logic [erx_pkg::HASH_WIDTH-1:0]       rsp_hash_index,
   output logic [erx_pkg::COUNT_WIDTH-1:0]      rsp_frame_count,
   output logic [erx_pkg::COUNT_WIDTH-1:0]      rsp_broadcast_count,
   output logic [erx_pkg::COUNT_WIDTH-1:0]      rsp_multicast_count,
   output logic [erx_pkg::OVER_WIDTH-1:0]       rsp_too_long_count
);
   import erx_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   entry_type front_entry;
   entry_type head_entry;
   logic      queue_full;
   logic      queue_empty;
   logic      push;
   logic      pop;

   // Configuration registers, written one at a time
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_STATION_MAC:   cfg_in.station_mac          = csr_data[MAC_WIDTH-1:0];
            CSR_HASH_TABLE:    cfg_in.hash_table           = csr_data[TABLE_WIDTH-1:0];
            CSR_ACCEPT_ALL:    cfg_in.accept_all           = csr_data[0];
            CSR_ACCEPT_BCAST:  cfg_in.accept_broadcast     = csr_data[0];
            CSR_ACCEPT_ALL_MC: cfg_in.accept_all_multicast = csr_data[0];
            CSR_HASH_ENABLE:   cfg_in.hash_enable          = csr_data[0];
            CSR_JUMBO_ENABLE:  cfg_in.jumbo_enable         = csr_data[0];
            CSR_GIGABIT_MODE:  cfg_in.gigabit_mode         = csr_data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: classify the incoming request
   erx_front #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_front (
      .cfg          (cfg_ff),
      .dest_mac     (req_dest_mac),
      .ether_type   (req_ether_type),
      .frame_length (req_frame_length),
      .entry        (front_entry)
   );

   // Queue between the two halves
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   erx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // Back: counters and result register
   erx_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_entry          (head_entry),
      .queue_empty         (queue_empty),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_accept          (rsp_accept),
      .rsp_drop_reason     (rsp_drop_reason),
      .rsp_is_broadcast    (rsp_is_broadcast),
      .rsp_is_multicast    (rsp_is_multicast),
      .rsp_hash_index      (rsp_hash_index),
      .rsp_frame_count     (rsp_frame_count),
      .rsp_broadcast_count (rsp_broadcast_count),
      .rsp_multicast_count (rsp_multicast_count),
      .rsp_too_long_count  (rsp_too_long_count)
   );

endmodule

// ===== rtl/erx_front.sv =====
// ----------------------------------------------------------------------------
// erx_front: classification of a frame header
// Works out broadcast and multicast class, the multicast hash, the length
// check and the drop reason of one request, ready to be queued.
// ----------------------------------------------------------------------------
module erx_front #(
   parameter int unsigned LENGTH_WIDTH = 14
) (
   input  erx_pkg::cfg_type                   cfg,
   input  logic [erx_pkg::MAC_WIDTH-1:0]      dest_mac,
   input  logic [erx_pkg::ETYPE_WIDTH-1:0]    ether_type,
   input  logic [LENGTH_WIDTH-1:0]            frame_length,
   output erx_pkg::entry_type                 entry
);
   import erx_pkg::*;

   logic [31:0]            crc5;
   logic [31:0]            crc6;
   logic [HASH_WIDTH-1:0]  hash_idx;
   logic                   bcst;
   logic                   mcst;
   logic                   vlan;
   logic [LENGTH_WIDTH-1:0] limit;
   logic                   too_long;
   logic [REASON_WIDTH-1:0] reason;

   // CRC over the address bytes, byte 0 first; the last byte only in
   // the six byte mode
   always_comb begin
      crc5 = CRC_INIT;
      for (int k = 0; k < 5; k++) begin
         crc5 = crc_byte(crc5, dest_mac[MAC_WIDTH-1-8*k -: 8]);
      end
      crc6     = crc_byte(crc5, dest_mac[7:0]);
      hash_idx = cfg.gigabit_mode ? hash_of(crc5) : hash_of(crc6);
   end

   // Address class
   assign bcst = (dest_mac == BCAST_MAC);
   assign mcst = (dest_mac[MAC_WIDTH-1 -: 24] == MCAST_OUI) &&
                 (dest_mac[23:16] <= MCAST_MAX4);

   // Length limit, raised for a VLAN tag and for jumbo frames
   assign vlan = (ether_type == VLAN_TYPE);
   always_comb begin
      unique case ({cfg.jumbo_enable, vlan})
         2'b00:   limit = LENGTH_WIDTH'(LIMIT_STD);
         2'b01:   limit = LENGTH_WIDTH'(LIMIT_STD_VLAN);
         2'b10:   limit = LENGTH_WIDTH'(LIMIT_JUMBO);
         default: limit = LENGTH_WIDTH'(LIMIT_JUMBO_VLAN);
      endcase
   end
   assign too_long = (frame_length > limit);

   // Drop decision; broadcast and multicast exclude each other
   always_comb begin
      reason = REASON_NONE;
      if (too_long) begin
         reason = REASON_TOO_LONG;
      end else if (bcst) begin
         if (!cfg.accept_all && !cfg.accept_broadcast) begin
            reason = REASON_BCAST_OFF;
         end
      end else if (mcst) begin
         if (!cfg.accept_all && !cfg.accept_all_multicast) begin
            if (!cfg.hash_enable) begin
               reason = REASON_MCAST_OFF;
            end else if (!cfg.hash_table[hash_idx]) begin
               reason = REASON_HASH_MISS;
            end
         end
      end else if (!cfg.accept_all && (dest_mac != cfg.station_mac)) begin
         reason = REASON_UCAST_MIS;
      end
   end

   assign entry.accept       = (reason == REASON_NONE);
   assign entry.drop_reason  = reason;
   assign entry.is_broadcast = bcst;
   assign entry.is_multicast = mcst;
   assign entry.hash_index   = hash_idx;
   assign entry.too_long     = too_long;

endmodule

// ===== rtl/erx_queue.sv =====
// ----------------------------------------------------------------------------
// erx_queue: short queue between classifier and back end
// A small register queue of classified requests, so that the front and the
// back can stall independently.
// ----------------------------------------------------------------------------
module erx_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  erx_pkg::entry_type  push_entry,
   input  logic                pop,
   output erx_pkg::entry_type  head_entry,
   output logic                full,
   output logic                empty
);
   import erx_pkg::*;

   localparam int unsigned PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   entry_type              entries_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff;
   logic [PTR_WIDTH-1:0]   wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [PTR_WIDTH-1:0]   rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff;
   logic [CNT_WIDTH-1:0]   count_in;

   assign full       = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   // Pointer and fill level update, pointers wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/erx_back.sv =====
// ----------------------------------------------------------------------------
// erx_back: statistics counters and result register
// Takes classified requests in order, advances the frame counters and holds
// the result until the receiving side takes it.
// ----------------------------------------------------------------------------
module erx_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  erx_pkg::entry_type                   head_entry,
   input  logic                                 queue_empty,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_accept,
   output logic [erx_pkg::REASON_WIDTH-1:0]     rsp_drop_reason,
   output logic                                 rsp_is_broadcast,
   output logic                                 rsp_is_multicast,
   output logic [erx_pkg::HASH_WIDTH-1:0]       rsp_hash_index,
   output logic [erx_pkg::COUNT_WIDTH-1:0]      rsp_frame_count,
   output logic [erx_pkg::COUNT_WIDTH-1:0]      rsp_broadcast_count,
   output logic [erx_pkg::COUNT_WIDTH-1:0]      rsp_multicast_count,
   output logic [erx_pkg::OVER_WIDTH-1:0]       rsp_too_long_count
);
   import erx_pkg::*;

   logic                   valid_ff;
   logic                   valid_in;
   entry_type              result_ff;
   logic [COUNT_WIDTH-1:0] frames_ff;
   logic [COUNT_WIDTH-1:0] frames_in;
   logic [COUNT_WIDTH-1:0] bcasts_ff;
   logic [COUNT_WIDTH-1:0] bcasts_in;
   logic [COUNT_WIDTH-1:0] mcasts_ff;
   logic [COUNT_WIDTH-1:0] mcasts_in;
   logic [OVER_WIDTH-1:0]  oversize_ff;
   logic [OVER_WIDTH-1:0]  oversize_in;

   // Take the next request when the result register is free or being taken
   assign pop = !queue_empty && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   // Counters move only when a request is taken, so they always match
   // the result on show
   always_comb begin
      frames_in   = frames_ff;
      bcasts_in   = bcasts_ff;
      mcasts_in   = mcasts_ff;
      oversize_in = oversize_ff;
      if (pop) begin
         frames_in = frames_ff + 1'b1;
         if (head_entry.too_long) begin
            oversize_in = oversize_ff + 1'b1;
         end else begin
            if (head_entry.is_broadcast) begin
               bcasts_in = bcasts_ff + 1'b1;
            end
            if (head_entry.is_multicast) begin
               mcasts_in = mcasts_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         frames_ff   <= '0;
         bcasts_ff   <= '0;
         mcasts_ff   <= '0;
         oversize_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         frames_ff   <= frames_in;
         bcasts_ff   <= bcasts_in;
         mcasts_ff   <= mcasts_in;
         oversize_ff <= oversize_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= head_entry;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_accept          = result_ff.accept;
   assign rsp_drop_reason     = result_ff.drop_reason;
   assign rsp_is_broadcast    = result_ff.is_broadcast;
   assign rsp_is_multicast    = result_ff.is_multicast;
   assign rsp_hash_index      = result_ff.hash_index;
   assign rsp_frame_count     = frames_ff;
   assign rsp_broadcast_count = bcasts_ff;
   assign rsp_multicast_count = mcasts_ff;
   assign rsp_too_long_count  = oversize_ff;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the receive address filter
// A short table of directed frame headers and register writes is walked
// first, followed by phases of random headers under fixed and random filter settings.
// Every result is compared field by field with a predictor kept in step with
// the configuration and the frame counters.
// ----------------------------------------------------------------------------
module testbench;
   import erx_pkg::*;

   localparam int unsigned LEN_W       = 14;
   localparam int unsigned LEN_MAX     = (1 << LEN_W) - 1;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PHASES      = 8;
   localparam int unsigned PHASE_ITEMS = 118;
   localparam int unsigned PRINT_LIMIT = 100;

   // Expected outcome of one request
   typedef struct packed {
      logic                    accept;
      logic [REASON_WIDTH-1:0] drop_reason;
      logic                    is_broadcast;
      logic                    is_multicast;
      logic [HASH_WIDTH-1:0]   hash_index;
      logic [COUNT_WIDTH-1:0]  frame_count;
      logic [COUNT_WIDTH-1:0]  broadcast_count;
      logic [COUNT_WIDTH-1:0]  multicast_count;
      logic [OVER_WIDTH-1:0]   too_long_count;
   } verdict_type;

   typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_type;

   // One line of the directed table: a frame header or a register write
   typedef struct {
      row_kind_type            kind;
      logic [MAC_WIDTH-1:0]    dest;
      logic [ETYPE_WIDTH-1:0]  etype;
      logic [LEN_W-1:0]        len;
      logic                    typed;
      logic [REASON_WIDTH-1:0] reason;
      logic [CSR_IDX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0] data;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_WIDTH-1:0]   csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;
   logic                       req_valid;
   logic                       req_stall;
   logic [MAC_WIDTH-1:0]       req_dest_mac;
   logic [ETYPE_WIDTH-1:0]     req_ether_type;
   logic [LEN_W-1:0]           req_frame_length;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_accept;
   logic [REASON_WIDTH-1:0]    rsp_drop_reason;
   logic                       rsp_is_broadcast;
   logic                       rsp_is_multicast;
   logic [HASH_WIDTH-1:0]      rsp_hash_index;
   logic [COUNT_WIDTH-1:0]     rsp_frame_count;
   logic [COUNT_WIDTH-1:0]     rsp_broadcast_count;
   logic [COUNT_WIDTH-1:0]     rsp_multicast_count;
   logic [OVER_WIDTH-1:0]      rsp_too_long_count;

   // Directed rows carry a typed verdict alongside the payload
   logic                    row_typed;
   logic [REASON_WIDTH-1:0] row_reason;

   // Filter settings and counters as the predictor sees them
   logic [MAC_WIDTH-1:0]   cfg_station  = '0;
   logic [TABLE_WIDTH-1:0] cfg_table    = '0;
   logic                   cfg_all      = 1'b0;
   logic                   cfg_bcast    = 1'b0;
   logic                   cfg_all_mc   = 1'b0;
   logic                   cfg_hash_en  = 1'b0;
   logic                   cfg_jumbo    = 1'b0;
   logic                   cfg_gigabit  = 1'b0;
   logic [COUNT_WIDTH-1:0] seen_frames   = '0;
   logic [COUNT_WIDTH-1:0] seen_bcast    = '0;
   logic [COUNT_WIDTH-1:0] seen_mcast    = '0;
   logic [OVER_WIDTH-1:0]  seen_oversize = '0;

   verdict_type verdicts_due[$];
   row_type     directed[$];
   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;
   int unsigned rsp_hold    = 0;
   logic        idling      = 1'b1;

   ethernet_rx_address_filter #(
      .LENGTH_WIDTH (LEN_W)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_dest_mac        (req_dest_mac),
      .req_ether_type      (req_ether_type),
      .req_frame_length    (req_frame_length),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_accept          (rsp_accept),
      .rsp_drop_reason     (rsp_drop_reason),
      .rsp_is_broadcast    (rsp_is_broadcast),
      .rsp_is_multicast    (rsp_is_multicast),
      .rsp_hash_index      (rsp_hash_index),
      .rsp_frame_count     (rsp_frame_count),
      .rsp_broadcast_count (rsp_broadcast_count),
      .rsp_multicast_count (rsp_multicast_count),
      .rsp_too_long_count  (rsp_too_long_count)
   );

   always #5 clock = ~clock;

   // Reflected CRC-32 over the leading address bytes, folded to six bits
   function automatic logic [HASH_WIDTH-1:0] multicast_hash(input logic [MAC_WIDTH-1:0] mac,
                                                            input logic five);
      logic [31:0]           crc;
      logic [7:0]            octet;
      logic                  fb;
      logic [HASH_WIDTH-1:0] idx;
      int unsigned           nbytes;
      crc    = 32'hffff_ffff;
      nbytes = five ? 5 : 6;
      for (int k = 0; k < nbytes; k++) begin
         octet = mac[47 - 8 * k -: 8];
         for (int b = 0; b < 8; b++) begin
            fb  = crc[31] ^ octet[b];
            crc = {crc[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
         end
      end
      crc = ~crc;
      // The top byte reversed, then its upper six bits
      for (int i = 0; i < HASH_WIDTH; i++) begin
         idx[i] = crc[29 - i];
      end
      return idx;
   endfunction

   // Classify one frame header and advance the counters
   function automatic verdict_type classify_frame(input logic [MAC_WIDTH-1:0]   dest,
                                                  input logic [ETYPE_WIDTH-1:0] etype,
                                                  input logic [LEN_W-1:0]       len);
      verdict_type      v;
      logic [LEN_W-1:0] lim;
      v              = '0;
      v.is_broadcast = dest == BCAST_MAC;
      v.is_multicast = dest[47:24] == MCAST_OUI && dest[23:16] <= MCAST_MAX4;
      v.hash_index   = multicast_hash(dest, cfg_gigabit);
      v.drop_reason  = REASON_NONE;
      seen_frames    = seen_frames + 1'b1;
      if (cfg_jumbo) begin
         lim = (etype == VLAN_TYPE) ? LIMIT_JUMBO_VLAN : LIMIT_JUMBO;
      end else begin
         lim = (etype == VLAN_TYPE) ? LIMIT_STD_VLAN : LIMIT_STD;
      end
      if (len > lim) begin
         seen_oversize = seen_oversize + 1'b1;
         v.drop_reason = REASON_TOO_LONG;
      end else begin
         if (v.is_broadcast) begin
            seen_bcast = seen_bcast + 1'b1;
            if (!cfg_all && !cfg_bcast) v.drop_reason = REASON_BCAST_OFF;
         end
         if (v.is_multicast) begin
            seen_mcast = seen_mcast + 1'b1;
            if (!cfg_all && !cfg_all_mc) begin
               if (!cfg_hash_en) begin
                  v.drop_reason = REASON_MCAST_OFF;
               end else if (!cfg_table[v.hash_index]) begin
                  v.drop_reason = REASON_HASH_MISS;
               end
            end
         end
         // Anything neither broadcast nor IPv4 multicast must be our own address
         if (v.drop_reason == REASON_NONE && !cfg_all && !v.is_broadcast &&
             !v.is_multicast && dest != cfg_station) begin
            v.drop_reason = REASON_UCAST_MIS;
         end
      end
      v.accept          = v.drop_reason == REASON_NONE;
      v.frame_count     = seen_frames;
      v.broadcast_count = seen_bcast;
      v.multicast_count = seen_mcast;
      v.too_long_count  = seen_oversize;
      return v;
   endfunction

   // Register write as the predictor applies it
   function automatic void apply_register(input logic [CSR_IDX_WIDTH-1:0]  idx,
                                          input logic [CSR_DATA_WIDTH-1:0] data);
      case (idx)
         CSR_STATION_MAC:   cfg_station = data[MAC_WIDTH-1:0];
         CSR_HASH_TABLE:    cfg_table   = data;
         CSR_ACCEPT_ALL:    cfg_all     = data[0];
         CSR_ACCEPT_BCAST:  cfg_bcast   = data[0];
         CSR_ACCEPT_ALL_MC: cfg_all_mc  = data[0];
         CSR_HASH_ENABLE:   cfg_hash_en = data[0];
         CSR_JUMBO_ENABLE:  cfg_jumbo   = data[0];
         CSR_GIGABIT_MODE:  cfg_gigabit = data[0];
         default: ;
      endcase
   endfunction

   // Idle stretch length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned sel;
      sel = $urandom_range(99);
      if (!idling || sel < 55) return 0;
      if (sel < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Destination mix weighted towards the interesting address classes
   function automatic logic [MAC_WIDTH-1:0] pick_dest();
      int unsigned          sel;
      logic [MAC_WIDTH-1:0] d;
      logic [63:0]          r;
      sel = $urandom_range(99);
      r   = {$urandom, $urandom};
      d   = r[MAC_WIDTH-1:0];
      if (sel < 10) begin
         d = BCAST_MAC;
      end else if (sel < 14) begin
         d = BCAST_MAC ^ (48'd1 << $urandom_range(47));
      end else if (sel < 42) begin
         d = {MCAST_OUI, 1'b0, d[22:0]};
      end else if (sel < 48) begin
         d = {MCAST_OUI, 1'b1, d[22:0]};
      end else if (sel < 64) begin
         d = cfg_station;
      end else if (sel < 70) begin
         d = cfg_station ^ (48'd1 << $urandom_range(47));
      end
      return d;
   endfunction

   function automatic logic [ETYPE_WIDTH-1:0] pick_etype();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 35) return VLAN_TYPE;
      if (sel < 45) return VLAN_TYPE ^ (16'd1 << $urandom_range(15));
      return ETYPE_WIDTH'($urandom);
   endfunction

   // Lengths cluster around the four limits, with a spread over the range
   function automatic logic [LEN_W-1:0] pick_length();
      int unsigned sel;
      int unsigned lim;
      sel = $urandom_range(99);
      if (sel < 40) return LEN_W'($urandom_range(1600, 14));
      if (sel < 75) begin
         case ($urandom_range(3))
            0:       lim = 32'(LIMIT_STD);
            1:       lim = 32'(LIMIT_STD_VLAN);
            2:       lim = 32'(LIMIT_JUMBO);
            default: lim = 32'(LIMIT_JUMBO_VLAN);
         endcase
         return LEN_W'(lim + $urandom_range(4) - 2);
      end
      return LEN_W'($urandom_range(LEN_MAX, 14));
   endfunction

   function automatic row_type fixed_frame(input logic [MAC_WIDTH-1:0]    dest,
                                           input logic [ETYPE_WIDTH-1:0]  etype,
                                           input logic [LEN_W-1:0]        len,
                                           input logic [REASON_WIDTH-1:0] reason);
      row_type r;
      r = '{kind: ROW_FRAME, dest: dest, etype: etype, len: len, typed: 1'b1,
            reason: reason, index: '0, data: '0};
      return r;
   endfunction

   function automatic row_type free_frame(input logic [MAC_WIDTH-1:0]   dest,
                                          input logic [ETYPE_WIDTH-1:0] etype,
                                          input logic [LEN_W-1:0]       len);
      row_type r;
      r = '{kind: ROW_FRAME, dest: dest, etype: etype, len: len, typed: 1'b0,
            reason: REASON_NONE, index: '0, data: '0};
      return r;
   endfunction

   function automatic row_type reg_write(input logic [CSR_IDX_WIDTH-1:0]  idx,
                                         input logic [CSR_DATA_WIDTH-1:0] data);
      row_type r;
      r = '{kind: ROW_WRITE, dest: '0, etype: '0, len: '0, typed: 1'b0,
            reason: REASON_NONE, index: idx, data: data};
      return r;
   endfunction

   // Printing stops after a while so that a broken block cannot flood the log
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < PRINT_LIMIT) begin
         $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      end
      mismatches++;
   endtask

   // Present one request and hold it until the block takes it
   task automatic send_frame(input logic [MAC_WIDTH-1:0]    dest,
                             input logic [ETYPE_WIDTH-1:0]  etype,
                             input logic [LEN_W-1:0]        len,
                             input logic                    typed,
                             input logic [REASON_WIDTH-1:0] reason);
      int unsigned gap;
      req_valid        <= 1'b1;
      req_dest_mac     <= dest;
      req_ether_type   <= etype;
      req_frame_length <= len;
      row_typed        <= typed;
      row_reason       <= reason;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // One register write; the caller lowers csr_valid after the last of a run
   task automatic csr_write(input logic [CSR_IDX_WIDTH-1:0]  idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_register(idx, data);
      @(negedge clock);
   endtask

   // Stop requesting and let every outstanding result come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(negedge clock);
   endtask

   // Settings for one random phase: all clear, all set, then random
   task automatic program_phase(input int unsigned phase);
      logic [63:0] station_w;
      logic [63:0] table_w;
      logic [63:0] noise;
      logic [5:0]  flags;
      noise     = {$urandom, $urandom};
      station_w = {$urandom, $urandom};
      table_w   = {$urandom, $urandom};
      flags     = 6'($urandom);
      if ($urandom_range(3) != 0) flags[0] = 1'b0;
      if ($urandom_range(9) < 3) station_w[47:23] = {MCAST_OUI, 1'b1};
      if (phase == 0) begin
         station_w = '0;
         table_w   = '0;
         flags     = '0;
      end else if (phase == 1) begin
         station_w = '1;
         table_w   = '1;
         flags     = '1;
      end
      csr_write(CSR_STATION_MAC,   station_w);
      csr_write(CSR_HASH_TABLE,    table_w);
      csr_write(CSR_ACCEPT_ALL,    {noise[63:1], flags[0]});
      csr_write(CSR_ACCEPT_BCAST,  {noise[62:0], flags[1]});
      csr_write(CSR_ACCEPT_ALL_MC, {noise[61:0], noise[63], flags[2]});
      csr_write(CSR_HASH_ENABLE,   {noise[60:0], noise[63:62], flags[3]});
      csr_write(CSR_JUMBO_ENABLE,  {~noise[63:1], flags[4]});
      csr_write(CSR_GIGABIT_MODE,  {~noise[62:0], flags[5]});
      csr_valid <= 1'b0;
   endtask

   // Result stall: runs of random length, separated by open cycles
   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold  = rsp_hold - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         rsp_hold  = pick_gap();
      end
   end

   // Check each result against the oldest expectation, then record new requests
   always @(posedge clock) begin : monitor
      verdict_type got;
      verdict_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_accept, rsp_drop_reason, rsp_is_broadcast, rsp_is_multicast,
                    rsp_hash_index, rsp_frame_count, rsp_broadcast_count,
                    rsp_multicast_count, rsp_too_long_count};
            if (verdicts_due.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_frame_count, '0);
            end else begin
               want = verdicts_due.pop_front();
               if (got.accept !== want.accept)
                  report_mismatch("accept", got.accept, want.accept);
               if (got.drop_reason !== want.drop_reason)
                  report_mismatch("drop_reason", got.drop_reason, want.drop_reason);
               if (got.is_broadcast !== want.is_broadcast)
                  report_mismatch("is_broadcast", got.is_broadcast, want.is_broadcast);
               if (got.is_multicast !== want.is_multicast)
                  report_mismatch("is_multicast", got.is_multicast, want.is_multicast);
               if (got.hash_index !== want.hash_index)
                  report_mismatch("hash_index", got.hash_index, want.hash_index);
               if (got.frame_count !== want.frame_count)
                  report_mismatch("frame_count", got.frame_count, want.frame_count);
               if (got.broadcast_count !== want.broadcast_count)
                  report_mismatch("broadcast_count", got.broadcast_count,
                                  want.broadcast_count);
               if (got.multicast_count !== want.multicast_count)
                  report_mismatch("multicast_count", got.multicast_count,
                                  want.multicast_count);
               if (got.too_long_count !== want.too_long_count)
                  report_mismatch("too_long_count", got.too_long_count,
                                  want.too_long_count);
            end
         end
         if (req_valid && !req_stall) begin
            want = classify_frame(req_dest_mac, req_ether_type, req_frame_length);
            if (row_typed) begin
               want.drop_reason = row_reason;
               want.accept      = row_reason == REASON_NONE;
            end
            verdicts_due.push_back(want);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[ethernet_rx_address_filter] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      logic writing;
      writing          = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      req_valid        = 1'b0;
      req_dest_mac     = '0;
      req_ether_type   = '0;
      req_frame_length = '0;
      row_typed        = 1'b0;
      row_reason       = REASON_NONE;

      // Reset settings: nothing but our all-zero address gets through
      directed.push_back(fixed_frame(BCAST_MAC, 16'h0800, 64, REASON_BCAST_OFF));
      directed.push_back(fixed_frame(48'h0100_5e00_0001, 16'h0000, 64, REASON_MCAST_OFF));
      directed.push_back(fixed_frame(48'h0100_5e7f_ffff, 16'h86dd, 64, REASON_MCAST_OFF));
      // Fourth byte above 0x7f is not IPv4 multicast and is filtered as unicast
      directed.push_back(fixed_frame(48'h0100_5e80_0000, 16'h0800, 64, REASON_UCAST_MIS));
      directed.push_back(fixed_frame(48'h0, 16'h0800, 14, REASON_NONE));
      directed.push_back(fixed_frame(48'h0, 16'h0800, 1514, REASON_NONE));
      directed.push_back(fixed_frame(48'h0, 16'h0800, 1515, REASON_TOO_LONG));
      directed.push_back(fixed_frame(48'h0, VLAN_TYPE, 1518, REASON_NONE));
      directed.push_back(fixed_frame(48'h0, VLAN_TYPE, 1519, REASON_TOO_LONG));
      // An oversized broadcast must not reach the broadcast counter
      directed.push_back(fixed_frame(BCAST_MAC, 16'h0800, LEN_W'(LEN_MAX), REASON_TOO_LONG));

      // Jumbo limits, broadcast on, hash table fully open; upper data bits ignored
      directed.push_back(reg_write(CSR_STATION_MAC, 64'hffff_0123_4567_89ab));
      directed.push_back(reg_write(CSR_JUMBO_ENABLE, 64'hffff_ffff_ffff_ffff));
      directed.push_back(reg_write(CSR_ACCEPT_BCAST, 64'h1));
      directed.push_back(reg_write(CSR_HASH_ENABLE, 64'h8000_0000_0000_0001));
      directed.push_back(reg_write(CSR_HASH_TABLE, 64'hffff_ffff_ffff_ffff));
      directed.push_back(fixed_frame(48'h0123_4567_89ab, 16'h0800, 9212, REASON_NONE));
      directed.push_back(fixed_frame(48'h0123_4567_89ab, 16'h0800, 9213, REASON_TOO_LONG));
      directed.push_back(fixed_frame(48'h0123_4567_89ab, VLAN_TYPE, 9216, REASON_NONE));
      directed.push_back(fixed_frame(48'h0123_4567_89ab, VLAN_TYPE, 9217, REASON_TOO_LONG));
      directed.push_back(fixed_frame(BCAST_MAC, 16'hffff, 60, REASON_NONE));
      directed.push_back(fixed_frame(48'h0100_5e12_3456, 16'h0800, 60, REASON_NONE));
      directed.push_back(fixed_frame(48'h0123_4567_89aa, 16'h0800, 60, REASON_UCAST_MIS));

      // Empty table with the five-byte hash
      directed.push_back(reg_write(CSR_HASH_TABLE, 64'h0));
      directed.push_back(reg_write(CSR_GIGABIT_MODE, 64'h1));
      directed.push_back(fixed_frame(48'h0100_5e00_0001, 16'h0800, 60, REASON_HASH_MISS));
      directed.push_back(reg_write(CSR_ACCEPT_ALL_MC, 64'h1));
      directed.push_back(fixed_frame(48'h0100_5e7f_0000, 16'h0800, 60, REASON_NONE));

      // Promiscuous mode on its own
      directed.push_back(reg_write(CSR_ACCEPT_ALL, 64'h1));
      directed.push_back(reg_write(CSR_ACCEPT_BCAST, 64'hffff_ffff_ffff_fffe));
      directed.push_back(reg_write(CSR_ACCEPT_ALL_MC, 64'h0));
      directed.push_back(reg_write(CSR_HASH_ENABLE, 64'h0));
      directed.push_back(reg_write(CSR_JUMBO_ENABLE, 64'h0));
      directed.push_back(fixed_frame(BCAST_MAC, 16'h0800, 60, REASON_NONE));
      directed.push_back(fixed_frame(48'h0100_5e00_0001, 16'h0800, 60, REASON_NONE));
      directed.push_back(fixed_frame(48'haaaa_aaaa_aaaa, 16'h0800, 60, REASON_NONE));
      directed.push_back(fixed_frame(48'h5555_5555_5555, 16'h0800, 1515, REASON_TOO_LONG));

      // Six-byte hash against a mixed table
      directed.push_back(reg_write(CSR_ACCEPT_ALL, 64'h0));
      directed.push_back(reg_write(CSR_GIGABIT_MODE, 64'h0));
      directed.push_back(reg_write(CSR_HASH_TABLE, 64'h0123_4567_89ab_cdef));
      directed.push_back(reg_write(CSR_HASH_ENABLE, 64'h1));
      directed.push_back(free_frame(48'h0100_5e00_0001, 16'h0800, 60));
      directed.push_back(free_frame(48'h0100_5e2a_5c13, VLAN_TYPE, 100));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_WRITE) begin
            if (!writing) begin
               wait_idle();
               writing = 1'b1;
            end
            csr_write(directed[i].index, directed[i].data);
         end else begin
            if (writing) begin
               csr_valid <= 1'b0;
               writing = 1'b0;
            end
            send_frame(directed[i].dest, directed[i].etype, directed[i].len,
                       directed[i].typed, directed[i].reason);
         end
      end
      if (writing) csr_valid <= 1'b0;

      // Random phases, every third one without any idling
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         idling = (phase % 3) != 2;
         program_phase(phase);
         for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
            send_frame(pick_dest(), pick_etype(), pick_length(), 1'b0, REASON_NONE);
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ethernet_rx_address_filter] OK");
      end else begin
         $display("[ethernet_rx_address_filter] ERROR");
      end
      $finish;
   end

endmodule
